FILE: hw/rtl/pfsd_pkg.sv
// Package: shared types and constants of the polyline densifier.
package pfsd_pkg;

	localparam int COORD_W   = 16;
	localparam int STEP_W    = 15;
	localparam int UNIT_FRAC = 24;
	localparam logic [STEP_W-1:0] STEP_RESET = 15'd384;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      path_start;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic                      is_vertex;
		logic                      last_of_run;
		logic                      capped;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_COUNT,
		ST_SQRT,
		ST_DIVX,
		ST_DIVY,
		ST_PLX,
		ST_PLY,
		ST_EMIT,
		ST_VTX
	} state_t;

endpackage

FILE: hw/rtl/polyline_fixed_step_densifier_top.sv
// Top level: fixed-step polyline densifier with one shared sequential datapath.
// An echoed first vertex goes to the result register straight from its accepted request.
// Per segment: the squared length, the count steps up to the insert cap, the root,
// the x and y divisions, then PLX, PLY and EMIT per inserted point and VTX for the vertex.
// Throughput: one vertex at a time; the input is held off until the vertex result is loaded.
// Reset (arst_n low) clears step_length to 384, previous vertex to zero, no path open.
module polyline_fixed_step_densifier_top #(
	parameter int MAX_INSERTED = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pfsd_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pfsd_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [pfsd_pkg::STEP_W-1:0]       cfg_data
);
	localparam int CW  = pfsd_pkg::COORD_W;
	localparam int KW  = $clog2(MAX_INSERTED + 2);
	localparam int DW  = pfsd_pkg::STEP_W + KW;     // distance k*step
	localparam int QW  = 2 * CW + 2;                // squared length
	localparam int RW  = CW + 1;                    // root width
	localparam int NW  = CW + 1 + pfsd_pkg::UNIT_FRAC; // dividend width
	localparam int PW  = DW + NW;                   // product width

	pfsd_pkg::state_t st_q, st_d;
	logic [pfsd_pkg::STEP_W-1:0] step_q;
	logic signed [CW-1:0] px_q, py_q, qx_q, qy_q;
	logic path_open_q;
	logic [CW:0]  ax_q, ay_q;
	logic sx_q, sy_q;
	logic [QW-1:0] d2_q;
	logic [KW-1:0] k_q, n_q;
	logic [DW-1:0] dist_q;
	logic cap_q;
	logic [5:0] cnt_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [NW-1:0] num_q, quo_q, ux_q, uy_q;
	logic [RW:0] drem_q;
	logic [PW-1:0] prod_q;
	logic signed [CW-1:0] ox_q;
	pfsd_pkg::out_item_t obuf_q;
	logic ovalid_q;

	// shared helpers
	logic [QW-1:0] sq_term;
	logic [2*DW-1:0] t2;
	logic [RW+1:0] trial, rem_sh;
	logic [RW:0]   drem_sh;
	logic [NW-1:0] off;
	logic signed [CW+1:0] placed;
	logic signed [CW-1:0] sat;

	assign sq_term = QW'(ax_q * ax_q);
	assign t2      = dist_q * dist_q;
	assign rem_sh  = {rem_q[RW-1:0], d2_q[QW-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign drem_sh = {drem_q[RW-1:0], num_q[NW-1]};
	assign off     = NW'((prod_q + PW'(1 << (pfsd_pkg::UNIT_FRAC - 1))) >> pfsd_pkg::UNIT_FRAC);

	always_comb begin
		logic signed [CW+1:0] base;
		logic sgn;
		base = (CW+2)'(px_q);
		sgn  = sx_q;
		// the y product waits in prod_q while the point is emitted
		if (st_q == pfsd_pkg::ST_EMIT) begin
			base = (CW+2)'(py_q);
			sgn  = sy_q;
		end
		if (off > NW'((1 << (CW + 1)) - 1)) begin
			placed = sgn ? -(CW+2)'(2**CW) : (CW+2)'(2**CW);
		end else if (sgn) begin
			placed = base - (CW+2)'(off);
		end else begin
			placed = base + (CW+2)'(off);
		end
		if (placed < -(2**(CW-1)))      sat = {1'b1, {(CW-1){1'b0}}};
		else if (placed > 2**(CW-1)-1)  sat = {1'b0, {(CW-1){1'b1}}};
		else                            sat = placed[CW-1:0];
	end

	logic obuf_free;
	assign obuf_free = !ovalid_q || out_ready;
	assign in_ready  = (st_q == pfsd_pkg::ST_IDLE) && obuf_free;
	assign out_valid = ovalid_q;
	assign out_data  = obuf_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pfsd_pkg::ST_IDLE:  if (in_valid && in_ready) begin
				st_d = (in_data.path_start || !path_open_q) ? pfsd_pkg::ST_IDLE
					: pfsd_pkg::ST_SQ;
			end
			pfsd_pkg::ST_SQ:    if (cnt_q == 6'd1) st_d = pfsd_pkg::ST_COUNT;
			pfsd_pkg::ST_COUNT: if ((2*DW)'(d2_q) <= t2 || k_q == KW'(MAX_INSERTED + 1))
				st_d = pfsd_pkg::ST_SQRT;
			pfsd_pkg::ST_SQRT:  if (cnt_q == 6'd0) st_d = pfsd_pkg::ST_DIVX;
			pfsd_pkg::ST_DIVX:  if (cnt_q == 6'd0) st_d = pfsd_pkg::ST_DIVY;
			pfsd_pkg::ST_DIVY:  if (cnt_q == 6'd0)
				st_d = (n_q == '0) ? pfsd_pkg::ST_VTX : pfsd_pkg::ST_PLX;
			pfsd_pkg::ST_PLX:   st_d = pfsd_pkg::ST_PLY;
			pfsd_pkg::ST_PLY:   st_d = pfsd_pkg::ST_EMIT;
			pfsd_pkg::ST_EMIT:  if (obuf_free)
				st_d = (k_q == n_q) ? pfsd_pkg::ST_VTX : pfsd_pkg::ST_PLX;
			pfsd_pkg::ST_VTX:   if (obuf_free) st_d = pfsd_pkg::ST_IDLE;
			default:  st_d = pfsd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pfsd_pkg::ST_IDLE;
			step_q      <= pfsd_pkg::STEP_RESET;
			px_q        <= '0;
			py_q        <= '0;
			path_open_q <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) step_q <= cfg_data;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				pfsd_pkg::ST_IDLE: if (in_valid && in_ready) begin
					qx_q <= in_data.point_x;
					qy_q <= in_data.point_y;
					if (in_data.path_start || !path_open_q) begin
						// echo the first vertex of a path
						obuf_q      <= '{in_data.point_x, in_data.point_y, 1'b1, 1'b1, 1'b0};
						ovalid_q    <= 1'b1;
						px_q        <= in_data.point_x;
						py_q        <= in_data.point_y;
						path_open_q <= 1'b1;
					end else begin
						logic signed [CW:0] ddx, ddy;
						ddx = (CW+1)'(in_data.point_x) - (CW+1)'(px_q);
						ddy = (CW+1)'(in_data.point_y) - (CW+1)'(py_q);
						sx_q <= ddx[CW];
						sy_q <= ddy[CW];
						ax_q <= ddx[CW] ? (CW+1)'(-ddx) : (CW+1)'(ddx);
						ay_q <= ddy[CW] ? (CW+1)'(-ddy) : (CW+1)'(ddy);
						d2_q <= '0;
						cnt_q <= 6'd2;
					end
				end
				pfsd_pkg::ST_SQ: begin
					// accumulate ax^2 then ay^2 through one squarer
					d2_q  <= d2_q + sq_term;
					ax_q  <= ay_q;
					ay_q  <= ax_q;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						k_q    <= KW'(1);
						n_q    <= '0;
						dist_q <= DW'(step_q);
						cap_q  <= 1'b0;
					end
				end
				pfsd_pkg::ST_COUNT: begin
					if ((2*DW)'(d2_q) > t2) begin
						if (k_q == KW'(MAX_INSERTED + 1)) cap_q <= 1'b1;
						else n_q <= k_q;
					end
					k_q    <= k_q + KW'(1);
					dist_q <= dist_q + DW'(step_q);
					if (st_d == pfsd_pkg::ST_SQRT) begin
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= 6'(QW / 2 - 1);
					end
				end
				pfsd_pkg::ST_SQRT: begin
					// restoring root, one bit pair a cycle
					d2_q <= d2_q << 2;
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						num_q  <= (NW'(ax_q) << pfsd_pkg::UNIT_FRAC)
							+ NW'({root_q[RW-2:0], rem_sh >= trial} >> 1);
						drem_q <= '0;
						cnt_q  <= 6'(NW - 1);
					end
				end
				pfsd_pkg::ST_DIVX, pfsd_pkg::ST_DIVY: begin
					logic [NW-1:0] qn;
					qn = {quo_q[NW-2:0], 1'b0};
					if (root_q == '0) begin
						drem_q <= '0;
					end else if (drem_sh >= (RW+1)'(root_q)) begin
						drem_q <= drem_sh - (RW+1)'(root_q);
						qn[0]  = 1'b1;
					end else begin
						drem_q <= drem_sh;
					end
					quo_q <= qn;
					num_q <= num_q << 1;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						drem_q <= '0;
						cnt_q  <= 6'(NW - 1);
						if (st_q == pfsd_pkg::ST_DIVX) begin
							ux_q  <= qn;
							num_q <= (NW'(ay_q) << pfsd_pkg::UNIT_FRAC) + NW'(root_q >> 1);
						end else begin
							uy_q   <= qn;
							k_q    <= KW'(1);
							dist_q <= DW'(step_q);
						end
					end
				end
				// a unit component never exceeds 1.0, so its low bits carry it all
				pfsd_pkg::ST_PLX: prod_q <= PW'(dist_q * ux_q[pfsd_pkg::UNIT_FRAC:0]);
				pfsd_pkg::ST_PLY: begin
					ox_q   <= sat;
					prod_q <= PW'(dist_q * uy_q[pfsd_pkg::UNIT_FRAC:0]);
				end
				pfsd_pkg::ST_EMIT: if (obuf_free) begin
					obuf_q   <= '{ox_q, sat, 1'b0, 1'b0, cap_q};
					ovalid_q <= 1'b1;
					k_q      <= k_q + KW'(1);
					dist_q   <= dist_q + DW'(step_q);
				end
				pfsd_pkg::ST_VTX: if (obuf_free) begin
					obuf_q   <= '{qx_q, qy_q, 1'b1, 1'b1, cap_q};
					ovalid_q <= 1'b1;
					px_q     <= qx_q;
					py_q     <= qy_q;
				end
				default: ;
			endcase
		end
	end

	// a result is only loaded when the buffer is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("result buffer overwritten");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> st_q == pfsd_pkg::ST_IDLE)
		else $error("ready outside idle");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= KW'(MAX_INSERTED) || st_q == pfsd_pkg::ST_IDLE || st_q == pfsd_pkg::ST_SQ)
		else $error("insert count over cap");
endmodule
